@@ rtl/sca_pkg.sv @@
// Shared types, codes and default sizes for the size-class block allocator.
`default_nettype none
package sca_pkg;
    localparam int GRANULE_BYTES_DEF = 64;
    localparam int MAX_GRANULES_DEF  = 4096;
    localparam int NUM_CLASSES_DEF   = 13;

    localparam int ADDR_W    = 48;
    localparam int SIZE_W    = 32;
    localparam int GCOUNT_W  = 13;
    localparam int STATUS_W  = 3;
    localparam int CLS_OUT_W = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SLICE_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRANULES   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK         = 3'd0,
        STS_TOO_LARGE  = 3'd1,
        STS_EXHAUSTED  = 3'd2,
        STS_BAD_ADDR   = 3'd3,
        STS_NOT_START  = 3'd4,
        STS_DOUBLE     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        GS_NONE = 2'd0,
        GS_LIVE = 2'd1,
        GS_FREE = 2'd2
    } t_gstate;

    typedef struct packed {
        logic              cmd;
        logic [SIZE_W-1:0] size_bytes;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ADDR_W-1:0]    block_address;
        logic [CLS_OUT_W-1:0] block_class;
    } t_rsp;
endpackage
`default_nettype wire

@@ rtl/sca_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module sca_ram import sca_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/size_class_block_allocator_core.sv @@
// Top level of the size-class block allocator: sequencer, list heads and memories.
// Allocate: a block of the request's class is taken from its list, else from the bump cursor, else a
// larger free block is split down and its upper halves are pushed onto the lower lists.
// A null free or an oversize allocate ends early.
// Throughput: one request at a time; the next is taken once the result is in the output register.
// Reset: synchronous; afterwards a clearing pass over all MAX_GRANULES granules empties the granule
// state, and no request is taken until it ends.
`default_nettype none
module size_class_block_allocator_core import sca_pkg::*; #(
    parameter int GRANULE_BYTES = GRANULE_BYTES_DEF,
    parameter int MAX_GRANULES  = MAX_GRANULES_DEF,
    parameter int NUM_CLASSES   = NUM_CLASSES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ADDR_W-1:0]    i_cfg_data,
    input  wire logic                 i_req_valid,
    output logic                      o_req_stall,
    input  wire t_req                 i_req,
    output logic                      o_rsp_valid,
    input  wire logic                 i_rsp_stall,
    output t_rsp                      o_rsp
);
    localparam int SH   = $clog2(GRANULE_BYTES);
    localparam int GW   = $clog2(MAX_GRANULES);
    localparam int HW   = GW + 1;
    localparam int CLW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int CW1  = $clog2(NUM_CLASSES + 1);
    localparam int SW   = ((HW > NUM_CLASSES) ? HW : NUM_CLASSES) + 1;
    localparam int MW   = 2 + CLW;
    localparam int NW   = SIZE_W + 1;
    localparam logic [HW-1:0] NO_LINK = HW'(MAX_GRANULES);

    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_CLASS = 14'b00000000000100,
        S_TRY   = 14'b00000000001000,
        S_SCAN  = 14'b00000000010000,
        S_POPW  = 14'b00000000100000,
        S_SPLIT = 14'b00000001000000,
        S_LIVE  = 14'b00000010000000,
        S_FCHK  = 14'b00000100000000,
        S_FCHK2 = 14'b00001000000000,
        S_FRD   = 14'b00010000000000,
        S_FDEC  = 14'b00100000000000,
        S_DONE  = 14'b01000000000000,
        S_SPARE = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    logic [ADDR_W-1:0]   r_base;
    logic [GCOUNT_W-1:0] r_gcount;
    logic [HW-1:0]       r_head [NUM_CLASSES];
    logic [HW-1:0]       r_cursor, n_cursor;
    logic [SIZE_W-1:0]   r_bytes, n_bytes;
    logic [NW-1:0]       r_n, n_n;
    logic [CW1-1:0]      r_c, n_c;
    logic [CW1-1:0]      r_k, n_k;
    logic [CW1-1:0]      r_j, n_j;
    logic                r_split, n_split;
    logic [GW-1:0]       r_g, n_g;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [ADDR_W:0]     r_diff, n_diff;
    logic [ADDR_W:0]     r_span, n_span;
    logic [GW-1:0]       r_clr, n_clr;
    t_rsp                r_res, n_res;
    logic                r_out_valid;
    t_rsp                r_out;

    logic            hd_we;
    logic [CLW-1:0]  hd_idx;
    logic [HW-1:0]   hd_val;
    logic            lk_we;
    logic [GW-1:0]   lk_waddr, lk_raddr;
    logic [HW-1:0]   lk_wdata, lk_rdata;
    logic            mt_we;
    logic [GW-1:0]   mt_waddr;
    logic [MW-1:0]   mt_wdata, mt_rdata;

    logic [31:0]     lim32;
    logic [HW-1:0]   limit;
    logic [SW-1:0]   need, bump_sum, half;
    logic [CW1-1:0]  jn;
    logic [HW-1:0]   head_c, head_k, head_jn, head_m;
    t_gstate         m_state;
    logic [CLW-1:0]  m_cls;
    logic            out_load;

    sca_ram #(.WIDTH(HW), .DEPTH(MAX_GRANULES)) u_link (
        .i_clk(i_clk), .i_we(lk_we), .i_waddr(lk_waddr), .i_wdata(lk_wdata),
        .i_raddr(lk_raddr), .o_rdata(lk_rdata)
    );

    sca_ram #(.WIDTH(MW), .DEPTH(MAX_GRANULES)) u_meta (
        .i_clk(i_clk), .i_we(mt_we), .i_waddr(mt_waddr), .i_wdata(mt_wdata),
        .i_raddr(r_g), .o_rdata(mt_rdata)
    );

    assign lim32    = (32'(r_gcount) > 32'(MAX_GRANULES)) ? 32'(MAX_GRANULES) : 32'(r_gcount);
    assign limit    = lim32[HW-1:0];
    assign need     = SW'(1) << r_c;
    assign bump_sum = SW'(r_cursor) + need;
    assign jn       = r_j - CW1'(1);
    assign half     = SW'(r_g) + (SW'(1) << jn);
    assign head_c   = r_head[r_c[CLW-1:0]];
    assign head_k   = r_head[r_k[CLW-1:0]];
    assign head_jn  = r_head[jn[CLW-1:0]];
    assign m_state  = t_gstate'(mt_rdata[MW-1 -: 2]);
    assign m_cls    = mt_rdata[CLW-1:0];
    assign head_m   = r_head[m_cls];
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_rsp_stall);

    always_comb begin
        n_state  = r_state;
        n_cursor = r_cursor;
        n_bytes  = r_bytes;
        n_n      = r_n;
        n_c      = r_c;
        n_k      = r_k;
        n_j      = r_j;
        n_split  = r_split;
        n_g      = r_g;
        n_addr   = r_addr;
        n_diff   = r_diff;
        n_span   = r_span;
        n_clr    = r_clr;
        n_res    = r_res;
        hd_we    = 1'b0;
        hd_idx   = r_c[CLW-1:0];
        hd_val   = NO_LINK;
        lk_we    = 1'b0;
        lk_waddr = r_g;
        lk_wdata = head_c;
        lk_raddr = head_c[GW-1:0];
        mt_we    = 1'b0;
        mt_waddr = r_g;
        mt_wdata = {GS_LIVE, r_c[CLW-1:0]};
        case (r_state)
            S_CLEAR: begin
                mt_we    = 1'b1;
                mt_waddr = r_clr;
                mt_wdata = {GS_NONE, CLW'(0)};
                n_clr    = r_clr + GW'(1);
                if (r_clr == GW'(MAX_GRANULES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_res = '{status: STS_OK, block_address: '0, block_class: '0};
                    n_addr = i_req.address;
                    if (i_req.cmd == CMD_ALLOC) begin
                        n_bytes = (i_req.size_bytes == '0) ? SIZE_W'(1) : i_req.size_bytes;
                        n_n     = NW'(GRANULE_BYTES);
                        n_c     = '0;
                        n_state = S_CLASS;
                    end else if (i_req.address == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FCHK;
                    end
                end
            end
            S_CLASS: begin
                if (r_n < NW'(r_bytes) && r_c < CW1'(NUM_CLASSES)) begin
                    n_n = r_n << 1;
                    n_c = r_c + CW1'(1);
                end else if (r_c >= CW1'(NUM_CLASSES)) begin
                    n_res.status = STS_TOO_LARGE;
                    n_state = S_DONE;
                end else begin
                    n_state = S_TRY;
                end
            end
            S_TRY: begin
                lk_raddr = head_c[GW-1:0];
                if (head_c < NO_LINK) begin
                    n_g     = head_c[GW-1:0];
                    n_k     = r_c;
                    n_split = 1'b0;
                    n_state = S_POPW;
                end else if (bump_sum <= SW'(limit)) begin
                    n_g      = r_cursor[GW-1:0];
                    n_cursor = bump_sum[HW-1:0];
                    n_state  = S_LIVE;
                end else begin
                    n_k     = r_c + CW1'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                lk_raddr = head_k[GW-1:0];
                if (r_k >= CW1'(NUM_CLASSES)) begin
                    n_res.status = STS_EXHAUSTED;
                    n_state = S_DONE;
                end else if (head_k < NO_LINK) begin
                    n_g     = head_k[GW-1:0];
                    n_j     = r_k;
                    n_split = 1'b1;
                    n_state = S_POPW;
                end else begin
                    n_k = r_k + CW1'(1);
                end
            end
            S_POPW: begin
                hd_we   = 1'b1;
                hd_idx  = r_k[CLW-1:0];
                hd_val  = lk_rdata;
                n_state = r_split ? S_SPLIT : S_LIVE;
            end
            S_SPLIT: begin
                if (r_j == r_c) begin
                    n_state = S_LIVE;
                end else begin
                    n_j = jn;
                    if (half < SW'(MAX_GRANULES)) begin
                        mt_we    = 1'b1;
                        mt_waddr = half[GW-1:0];
                        mt_wdata = {GS_FREE, jn[CLW-1:0]};
                        lk_we    = 1'b1;
                        lk_waddr = half[GW-1:0];
                        lk_wdata = head_jn;
                        hd_we    = 1'b1;
                        hd_idx   = jn[CLW-1:0];
                        hd_val   = half[HW-1:0];
                    end
                end
            end
            S_LIVE: begin
                mt_we    = 1'b1;
                mt_waddr = r_g;
                mt_wdata = {GS_LIVE, r_c[CLW-1:0]};
                n_res.block_address = r_base + (ADDR_W'(r_g) << SH);
                n_res.block_class   = CLS_OUT_W'(r_c);
                n_state = S_DONE;
            end
            S_FCHK: begin
                n_diff  = {1'b0, r_addr} - {1'b0, r_base};
                n_span  = (ADDR_W + 1)'(limit) << SH;
                n_state = S_FCHK2;
            end
            S_FCHK2: begin
                if (r_diff[ADDR_W] || r_diff >= r_span || r_diff[SH-1:0] != '0) begin
                    n_res.status = STS_BAD_ADDR;
                    n_state = S_DONE;
                end else begin
                    n_g     = r_diff[SH +: GW];
                    n_state = S_FRD;
                end
            end
            S_FRD: begin
                n_state = S_FDEC;
            end
            S_FDEC: begin
                n_state = S_DONE;
                case (m_state)
                    GS_LIVE: begin
                        mt_we    = 1'b1;
                        mt_waddr = r_g;
                        mt_wdata = {GS_FREE, m_cls};
                        lk_we    = 1'b1;
                        lk_waddr = r_g;
                        lk_wdata = head_m;
                        hd_we    = 1'b1;
                        hd_idx   = m_cls;
                        hd_val   = HW'(r_g);
                        n_res.block_class = CLS_OUT_W'(m_cls);
                    end
                    GS_FREE: n_res.status = STS_DOUBLE;
                    default: n_res.status = STS_NOT_START;
                endcase
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cursor    <= '0;
            r_base      <= '0;
            r_gcount    <= GCOUNT_W'(4096);
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_head[i] <= NO_LINK;
            end
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_cursor <= n_cursor;
            if (hd_we) begin
                r_head[hd_idx] <= hd_val;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SLICE_BASE: r_base   <= i_cfg_data;
                    REG_GRANULES:   r_gcount <= i_cfg_data[GCOUNT_W-1:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        r_n     <= n_n;
        r_c     <= n_c;
        r_k     <= n_k;
        r_j     <= n_j;
        r_split <= n_split;
        r_g     <= n_g;
        r_addr  <= n_addr;
        r_diff  <= n_diff;
        r_span  <= n_span;
        r_res   <= n_res;
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

`ifndef ASSERT_OFF
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= HW'(MAX_GRANULES))
        else $error("bump cursor past the granule count");
    a_split_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT) |-> (r_j >= r_c))
        else $error("split walked below the requested class");
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(r_state == S_DONE))
        else $error("response raised outside the completion state");
`endif
endmodule
`default_nettype wire
